// ===== design/lfubc_pkg.sv =====
// ----------------------------------------------------------------------------
// lfubc_pkg: shared types and constants of the LFU block cache policy
// Holds the payload structs, the command and status bundles between the
// controller and the datapath, the state encoding and the mode codes.
// ----------------------------------------------------------------------------
`default_nettype none

package lfubc_pkg;

    // Fixed field widths.
    localparam int MODE_W    = 2;
    localparam int ADDR_W    = 32;
    localparam int BLOCK_W   = 32;
    localparam int SLOT_W    = 4;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;

    // Access modes.
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SYNC  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLOSE = 2'd3;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SHIFT = 1'd1;
    localparam logic [CFG_W-1:0]     CAPACITY_RST    = 5'd16;
    localparam logic [CFG_W-1:0]     BLOCK_SHIFT_RST = 5'd12;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ADDR_W-1:0] byte_address;
    } t_in;

    typedef struct packed {
        logic               hit;
        logic [SLOT_W-1:0]  slot;
        logic               fill;
        logic               victim_valid;
        logic [BLOCK_W-1:0] victim_block;
        logic               writeback;
        logic               last;
    } t_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_FLUSH
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic scan;
        logic flush;
        logic update;
        logic clear_all;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic scan_done;
        logic is_close;
    } t_sts;

endpackage : lfubc_pkg

`default_nettype wire

// ===== design/lfubc_ctrl.sv =====
// ----------------------------------------------------------------------------
// lfubc_ctrl: sequencing controller of the LFU block cache policy
// Steps each item through a tag scan and an update, or through a flush scan
// for sync and close, and drives the datapath with commands.
// ----------------------------------------------------------------------------
`default_nettype none

module lfubc_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    input  wire logic           i_access,
    input  wire lfubc_pkg::t_sts i_sts,
    output lfubc_pkg::t_cmd     o_cmd,
    output logic                busy
);
    import lfubc_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = i_access ? S_SCAN : S_FLUSH;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                n_state = S_IDLE;
            end
            S_FLUSH: begin
                if (i_sts.scan_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        case (r_state)
            S_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
            end
            S_FLUSH: begin
                o_cmd.scan      = 1'b1;
                o_cmd.flush     = 1'b1;
                o_cmd.clear_all = i_sts.scan_done && i_sts.is_close;
            end
            default: begin
                busy = 1'b0;
            end
        endcase
    end

endmodule : lfubc_ctrl

`default_nettype wire

// ===== design/lfubc_dpath.sv =====
// ----------------------------------------------------------------------------
// lfubc_dpath: tag store and scan datapath of the LFU block cache policy
// Holds the block and count memories, valid and dirty bits, the configuration
// registers, the one-entry-per-cycle scan trackers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lfubc_dpath #(
    parameter int MAX_ENTRIES = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [lfubc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [lfubc_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire lfubc_pkg::t_in                  i_in,
    input  wire lfubc_pkg::t_cmd                 i_cmd,
    output lfubc_pkg::t_sts                      o_sts,
    output lfubc_pkg::t_out                      o_out,
    output logic                                 o_out_valid
);
    import lfubc_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int UW    = $clog2(MAX_ENTRIES + 1);
    localparam int CW    = (UW > CFG_W) ? UW : CFG_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);
    localparam logic [CW-1:0]    CAP_MAX  = CW'(MAX_ENTRIES);
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

    // Configuration registers.
    logic [CFG_W-1:0] r_cap;
    logic [CFG_W-1:0] r_shift;

    // Item registers.
    logic [MODE_W-1:0]  r_mode;
    logic [BLOCK_W-1:0] r_blk;

    // Entry state.
    logic [MAX_ENTRIES-1:0] r_valid;
    logic [MAX_ENTRIES-1:0] r_dirty;
    logic [BLOCK_W-1:0]     mem_blk [MAX_ENTRIES];
    logic [COUNT_WIDTH-1:0] mem_cnt [MAX_ENTRIES];
    logic [BLOCK_W-1:0]     r_rd_blk;
    logic [COUNT_WIDTH-1:0] r_rd_cnt;

    // Scan pipeline.
    logic [IDX_W-1:0] r_addr_idx;
    logic             r_issue_done;
    logic             r_pend;
    logic [IDX_W-1:0] r_pend_idx;

    // Scan trackers.
    logic                   r_match;
    logic [IDX_W-1:0]       r_match_idx;
    logic [COUNT_WIDTH-1:0] r_match_cnt;
    logic [UW-1:0]          r_used;
    logic                   r_cand;
    logic [IDX_W-1:0]       r_min_idx;
    logic [COUNT_WIDTH-1:0] r_min_cnt;
    logic [BLOCK_W-1:0]     r_min_blk;
    logic                   r_free_found;
    logic [IDX_W-1:0]       r_free_idx;

    // Result register.
    t_out r_out;
    logic r_out_valid;
    t_out n_out;
    logic n_out_valid;

    logic                   eval_valid;
    logic                   flush_hit;
    logic                   hi_dirty;
    logic [CW-1:0]          cap_eff;
    logic                   evict;
    logic [IDX_W-1:0]       free_idx;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic                   is_write;
    logic                   blk_we;
    logic [IDX_W-1:0]       cnt_waddr;
    logic [COUNT_WIDTH-1:0] cnt_wdata;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= CAPACITY_RST;
            r_shift <= BLOCK_SHIFT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CAPACITY:    r_cap   <= i_cfg_data;
                CFG_BLOCK_SHIFT: r_shift <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Item capture; the block number is formed once at the transfer.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_in.mode;
            r_blk  <= i_in.byte_address >> r_shift;
        end
    end

    // Scan address issue and read-data tracking.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr_idx   <= '0;
            r_issue_done <= 1'b0;
            r_pend       <= 1'b0;
        end else if (i_cmd.load) begin
            r_addr_idx   <= '0;
            r_issue_done <= 1'b0;
            r_pend       <= 1'b0;
        end else begin
            r_pend <= i_cmd.scan && !r_issue_done;
            if (i_cmd.scan && !r_issue_done) begin
                r_pend_idx <= r_addr_idx;
                if (r_addr_idx == LAST_IDX) begin
                    r_issue_done <= 1'b1;
                end else begin
                    r_addr_idx <= r_addr_idx + 1'b1;
                end
            end
        end
    end

    // Block and count memories with registered reads at the scan address.
    always_ff @(posedge i_clk) begin
        if (blk_we) begin
            mem_blk[free_idx] <= r_blk;
        end
        r_rd_blk <= mem_blk[r_addr_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            mem_cnt[cnt_waddr] <= cnt_wdata;
        end
        r_rd_cnt <= mem_cnt[r_addr_idx];
    end

    assign eval_valid = r_pend && r_valid[r_pend_idx];
    assign flush_hit  = i_cmd.flush && eval_valid && r_dirty[r_pend_idx];

    // Any dirty entry above the one being examined decides the last flag.
    always_comb begin
        hi_dirty = 1'b0;
        for (int j = 0; j < MAX_ENTRIES; j++) begin
            if (r_valid[j] && r_dirty[j] && (IDX_W'(j) > r_pend_idx)) begin
                hi_dirty = 1'b1;
            end
        end
    end

    // Trackers: match, occupancy, least-count victim and first free entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match      <= 1'b0;
            r_used       <= '0;
            r_cand       <= 1'b0;
            r_free_found <= 1'b0;
        end else if (i_cmd.load) begin
            r_match      <= 1'b0;
            r_used       <= '0;
            r_cand       <= 1'b0;
            r_free_found <= 1'b0;
        end else if (r_pend) begin
            if (eval_valid) begin
                r_used <= r_used + 1'b1;
                if (!r_match && (r_rd_blk == r_blk)) begin
                    r_match     <= 1'b1;
                    r_match_idx <= r_pend_idx;
                    r_match_cnt <= r_rd_cnt;
                end
                if (!r_cand || (r_rd_cnt < r_min_cnt) ||
                    ((r_rd_cnt == r_min_cnt) && (r_rd_blk < r_min_blk))) begin
                    r_cand    <= 1'b1;
                    r_min_idx <= r_pend_idx;
                    r_min_cnt <= r_rd_cnt;
                    r_min_blk <= r_rd_blk;
                end
            end else if (!r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_pend_idx;
            end
        end
    end

    // Update decision: capacity clamp, eviction and free-entry choice.
    always_comb begin
        cap_eff = CW'(r_cap);
        if (cap_eff == '0) begin
            cap_eff = CW'(1);
        end else if (cap_eff > CAP_MAX) begin
            cap_eff = CAP_MAX;
        end
        evict = r_cand && (CW'(r_used) >= cap_eff);
        if (evict) begin
            free_idx = (r_free_found && (r_free_idx < r_min_idx)) ? r_free_idx : r_min_idx;
        end else begin
            free_idx = r_free_idx;
        end
        cnt_inc   = (r_match_cnt == '1) ? r_match_cnt : r_match_cnt + 1'b1;
        is_write  = (r_mode == MODE_WRITE);
        blk_we    = i_cmd.update && !r_match;
        cnt_waddr = r_match ? r_match_idx : free_idx;
        cnt_wdata = r_match ? cnt_inc : CNT_ONE;
    end

    // Valid and dirty bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_dirty <= '0;
        end else begin
            if (i_cmd.update) begin
                if (r_match) begin
                    if (is_write) begin
                        r_dirty[r_match_idx] <= 1'b1;
                    end
                end else begin
                    if (evict) begin
                        r_valid[r_min_idx] <= 1'b0;
                        r_dirty[r_min_idx] <= 1'b0;
                    end
                    r_valid[free_idx] <= 1'b1;
                    r_dirty[free_idx] <= is_write;
                end
            end
            if (flush_hit) begin
                r_dirty[r_pend_idx] <= 1'b0;
            end
            if (i_cmd.clear_all) begin
                r_valid <= '0;
                r_dirty <= '0;
            end
        end
    end

    // Result formation.
    always_comb begin
        n_out       = r_out;
        n_out_valid = 1'b0;
        if (i_cmd.update) begin
            n_out_valid = 1'b1;
            n_out.last  = 1'b1;
            if (r_match) begin
                n_out.hit          = 1'b1;
                n_out.slot         = SLOT_W'(r_match_idx);
                n_out.fill         = 1'b0;
                n_out.victim_valid = 1'b0;
                n_out.victim_block = '0;
                n_out.writeback    = 1'b0;
            end else begin
                n_out.hit          = 1'b0;
                n_out.slot         = SLOT_W'(free_idx);
                n_out.fill         = 1'b1;
                n_out.victim_valid = evict;
                n_out.victim_block = evict ? r_min_blk : '0;
                n_out.writeback    = evict && r_dirty[r_min_idx];
            end
        end else if (flush_hit) begin
            n_out_valid        = 1'b1;
            n_out.hit          = 1'b0;
            n_out.slot         = SLOT_W'(r_pend_idx);
            n_out.fill         = 1'b0;
            n_out.victim_valid = 1'b0;
            n_out.victim_block = r_rd_blk;
            n_out.writeback    = 1'b1;
            n_out.last         = !hi_dirty;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out          = r_out;
    assign o_out_valid    = r_out_valid;
    assign o_sts.scan_done = r_pend && (r_pend_idx == LAST_IDX);
    assign o_sts.is_close  = (r_mode == MODE_CLOSE);

endmodule : lfubc_dpath

`default_nettype wire

// ===== design/lfu_block_cache_policy.sv =====
// ----------------------------------------------------------------------------
// lfu_block_cache_policy: fully associative block cache tag store, LFU policy
// Looks up a block number in all entries, bumps saturating use counts, fills
// misses, evicts the least-count entry at capacity and flushes dirty entries.
//
//   channel  | ports                                       | transfer when
//   ---------+---------------------------------------------+-------------------
//   command  | start, busy, i_in (mode, byte_address)      | start && !busy
//   result   | o_out_valid, o_out (hit ... last)           | o_out_valid
//   config   | i_cfg_we, i_cfg_index, i_cfg_data           | i_cfg_we
//
// During a read or write the scan reads one entry per cycle from the block and
// count memories, which have a single registered read port, then the update
// state writes the entry. Sync and close give one result per dirty entry while
// the same scan passes over it.
// Synchronous active-low reset clears all entries and restores the registers.
// Results are strobed for one cycle; the receiver cannot stall them.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_block_cache_policy #(
    parameter int MAX_ENTRIES = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire lfubc_pkg::t_in                  i_in,
    output lfubc_pkg::t_out                      o_out,
    output logic                                 o_out_valid,
    input  wire logic                            i_cfg_we,
    input  wire logic [lfubc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [lfubc_pkg::CFG_W-1:0]     i_cfg_data
);
    import lfubc_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic access;

    assign access = (i_in.mode == MODE_READ) || (i_in.mode == MODE_WRITE);

    lfubc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_access (access),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    lfubc_dpath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out       (o_out),
        .o_out_valid (o_out_valid)
    );

    // An accepted command makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block idle right after a command transfer");

    // A flush result that is not the last one is followed by more scanning.
    a_not_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.last) |-> busy)
        else $error("non-final result while block is idle");

    // A hit never fills, evicts or writes back, and ends its item.
    a_hit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.hit) |->
            (!o_out.fill && !o_out.victim_valid && !o_out.writeback && o_out.last))
        else $error("hit result carries fill or eviction");

    // A write-back without a fill comes only from a flush, never a hit.
    a_flush_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.fill && !o_out.hit) |->
            (o_out.writeback && !o_out.victim_valid))
        else $error("malformed flush result");

endmodule : lfu_block_cache_policy

`default_nettype wire

// ===== tb/lfu_block_cache_policy_tb.sv =====
// ----------------------------------------------------------------------------
// lfu_block_cache_policy_tb: self-checking testbench for the LFU block cache
// Sends read, write, sync and close commands in random bursts and keeps its
// own copy of the tag store to work out every result transfer. Each strobed
// result is compared field by field with the oldest outstanding expectation.
// ----------------------------------------------------------------------------

module lfu_block_cache_policy_tb;
    import lfubc_pkg::*;

    localparam int NUM_ENTRIES   = 16;
    localparam int COUNT_W       = 16;
    localparam int SETTLE_CYCLES = NUM_ENTRIES + 8;
    localparam int PHASE_ITEMS   = 48;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 start       = 1'b0;
    logic                 busy;
    t_in                  i_in        = '0;
    t_out                 o_out;
    logic                 o_out_valid;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_CAPACITY;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    // Mirror of the tag store and of the two registers.
    logic               mir_valid [NUM_ENTRIES];
    logic [BLOCK_W-1:0] mir_block [NUM_ENTRIES];
    logic [COUNT_W-1:0] mir_count [NUM_ENTRIES];
    logic               mir_dirty [NUM_ENTRIES];
    logic [CFG_W-1:0]   mir_capacity = CAPACITY_RST;
    logic [CFG_W-1:0]   mir_shift    = BLOCK_SHIFT_RST;

    t_out due_responses[$];
    t_out want;
    int   mismatch_count = 0;
    int   burst_left     = 0;

    always #5 i_clk = ~i_clk;

    lfu_block_cache_policy #(
        .MAX_ENTRIES(NUM_ENTRIES),
        .COUNT_WIDTH(COUNT_W)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_in       (i_in),
        .o_out      (o_out),
        .o_out_valid(o_out_valid),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // Apply one accepted command to the mirror and queue the results it causes.
    task automatic update_tag_mirror(input t_in cmd);
        logic [BLOCK_W-1:0] blk;
        t_out resp;
        int found;
        int used;
        int cap;
        int victim;
        int free_idx;
        int last_dirty;
        resp = '0;
        if (cmd.mode == MODE_READ || cmd.mode == MODE_WRITE) begin
            blk = cmd.byte_address >> mir_shift;
            found = -1;
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                if (found < 0 && mir_valid[i] && mir_block[i] == blk) found = i;
            end
            resp.last = 1'b1;
            if (found >= 0) begin
                // Hit: saturating count bump, a write marks the entry dirty.
                if (mir_count[found] != '1) mir_count[found] = mir_count[found] + 1'b1;
                if (cmd.mode == MODE_WRITE) mir_dirty[found] = 1'b1;
                resp.hit = 1'b1;
                resp.slot = SLOT_W'(found);
            end else begin
                used = 0;
                for (int i = 0; i < NUM_ENTRIES; i++) begin
                    if (mir_valid[i]) used++;
                end
                // A capacity of zero behaves as one, anything above the size as full.
                cap = int'(mir_capacity);
                if (cap < 1) cap = 1;
                if (cap > NUM_ENTRIES) cap = NUM_ENTRIES;
                if (used >= cap) begin
                    // Lowest count goes first; ties go to the lowest block number.
                    victim = -1;
                    for (int i = 0; i < NUM_ENTRIES; i++) begin
                        if (mir_valid[i] && (victim < 0 || mir_count[i] < mir_count[victim] ||
                            (mir_count[i] == mir_count[victim] &&
                             mir_block[i] < mir_block[victim]))) begin
                            victim = i;
                        end
                    end
                    if (victim >= 0) begin
                        resp.victim_valid = 1'b1;
                        resp.victim_block = mir_block[victim];
                        resp.writeback = mir_dirty[victim];
                        mir_valid[victim] = 1'b0;
                        mir_dirty[victim] = 1'b0;
                        mir_count[victim] = '0;
                    end
                end
                free_idx = -1;
                for (int i = 0; i < NUM_ENTRIES; i++) begin
                    if (free_idx < 0 && !mir_valid[i]) free_idx = i;
                end
                if (free_idx < 0) free_idx = 0;
                mir_valid[free_idx] = 1'b1;
                mir_block[free_idx] = blk;
                mir_count[free_idx] = COUNT_W'(1);
                mir_dirty[free_idx] = (cmd.mode == MODE_WRITE);
                resp.fill = 1'b1;
                resp.slot = SLOT_W'(free_idx);
            end
            due_responses.push_back(resp);
        end else begin
            // Sync and close report every dirty entry in slot order.
            last_dirty = -1;
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                if (mir_valid[i] && mir_dirty[i]) last_dirty = i;
            end
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                if (mir_valid[i] && mir_dirty[i]) begin
                    resp = '0;
                    resp.slot = SLOT_W'(i);
                    resp.victim_block = mir_block[i];
                    resp.writeback = 1'b1;
                    resp.last = (i == last_dirty);
                    due_responses.push_back(resp);
                    mir_dirty[i] = 1'b0;
                end
            end
            if (cmd.mode == MODE_CLOSE) begin
                for (int i = 0; i < NUM_ENTRIES; i++) begin
                    mir_valid[i] = 1'b0;
                    mir_count[i] = '0;
                    mir_dirty[i] = 1'b0;
                end
            end
        end
    endtask

    task automatic compare_field(input string field, input logic [31:0] exp_val,
                                 input logic [31:0] got_val);
        if (got_val !== exp_val) begin
            mismatch_count++;
            $display("%0t ERROR %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, field, exp_val, got_val);
        end
    endtask

    // Check every result transfer against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid) begin
            if (due_responses.size() == 0) begin
                mismatch_count++;
                $display("%0t ERROR unexpected result: expected none, %s %0d block 0x%0h",
                         $time, "actual slot", o_out.slot, o_out.victim_block);
            end else begin
                want = due_responses.pop_front();
                compare_field("hit", 32'(want.hit), 32'(o_out.hit));
                compare_field("slot", 32'(want.slot), 32'(o_out.slot));
                compare_field("fill", 32'(want.fill), 32'(o_out.fill));
                compare_field("victim_valid", 32'(want.victim_valid),
                              32'(o_out.victim_valid));
                compare_field("victim_block", want.victim_block, o_out.victim_block);
                compare_field("writeback", 32'(want.writeback), 32'(o_out.writeback));
                compare_field("last", 32'(want.last), 32'(o_out.last));
            end
        end
    end

    // Hold a command on the port until its transfer; start stays high afterwards.
    task automatic issue_command(input logic [MODE_W-1:0] mode, input logic [ADDR_W-1:0] addr);
        t_in cmd;
        cmd.mode = mode;
        cmd.byte_address = addr;
        start <= 1'b1;
        i_in <= cmd;
        do @(posedge i_clk); while (busy !== 1'b0);
        update_tag_mirror(cmd);
    endtask

    // Bursts of back-to-back commands separated by random gaps.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_paced(input logic [MODE_W-1:0] mode, input logic [ADDR_W-1:0] addr);
        issue_command(mode, addr);
        pace_sender();
    endtask

    // Wait for all results, then for the scan that may still be running.
    task automatic drain_block();
        start <= 1'b0;
        while (due_responses.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_settings(input logic [CFG_W-1:0] cap, input logic [CFG_W-1:0] shift);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_CAPACITY;
        i_cfg_data <= cap;
        @(posedge i_clk);
        mir_capacity = cap;
        i_cfg_index <= CFG_BLOCK_SHIFT;
        i_cfg_data <= shift;
        @(posedge i_clk);
        mir_shift = shift;
        i_cfg_we <= 1'b0;
    endtask

    // Misses, hits within one block, dirty hits, a sync of dirty entries, then empty sync and close.
    task automatic test_hit_and_fill();
        send_paced(MODE_READ, 32'h0000_0000);
        send_paced(MODE_READ, 32'h0000_0FFF);
        send_paced(MODE_WRITE, 32'h0000_1000);
        send_paced(MODE_WRITE, 32'hFFFF_FFFF);
        send_paced(MODE_READ, 32'h0000_1234);
        send_paced(MODE_SYNC, 32'hFFFF_FFFF);
        send_paced(MODE_SYNC, 32'h0000_0000);
        send_paced(MODE_CLOSE, 32'h5555_5555);
        send_paced(MODE_READ, 32'h0000_0000);
        drain_block();
    endtask

    // Fill every entry with descending dirty blocks so the tie-break by block
    // number differs from slot order, flush all of them, then lower capacity.
    task automatic test_full_flush();
        write_settings(5'd31, 5'd0);
        send_paced(MODE_CLOSE, 32'h0);
        for (int i = 0; i <= NUM_ENTRIES; i++) send_paced(MODE_WRITE, 32'd200 - i);
        send_paced(MODE_SYNC, 32'h0);
        drain_block();
        write_settings(5'd2, 5'd0);
        send_paced(MODE_READ, 32'd500);
        send_paced(MODE_WRITE, 32'd501);
        send_paced(MODE_CLOSE, 32'h0);
        drain_block();
    endtask

    // Capacity zero acts as one entry; shifts of 16 and of 31, the largest.
    task automatic test_capacity_and_shift();
        write_settings(5'd0, 5'd16);
        send_paced(MODE_READ, 32'h0001_0000);
        send_paced(MODE_READ, 32'h0001_FFFF);
        send_paced(MODE_WRITE, 32'hFFFF_0000);
        send_paced(MODE_WRITE, 32'h0000_FFFF);
        send_paced(MODE_CLOSE, 32'h0);
        drain_block();
        write_settings(5'd16, 5'd31);
        send_paced(MODE_READ, 32'h7FFF_FFFF);
        send_paced(MODE_WRITE, 32'h8000_0000);
        send_paced(MODE_READ, 32'hFFFF_FFFF);
        send_paced(MODE_CLOSE, 32'h0);
        drain_block();
    endtask

    // Random traffic over small block pools, one register setting per phase.
    task automatic test_random_traffic();
        logic [CFG_W-1:0] cap_list [5];
        logic [CFG_W-1:0] shift_list [5];
        logic [31:0] pool [20];
        logic [31:0] low_mask;
        logic [MODE_W-1:0] mode;
        logic [ADDR_W-1:0] addr;
        int pool_size;
        int pick;
        cap_list = '{5'd4, 5'd16, 5'd1, 5'd31, 5'($urandom_range(0, 31))};
        shift_list = '{5'd12, 5'd0, 5'd31, 5'd16, 5'($urandom_range(0, 31))};
        for (int phase = 0; phase < 5; phase++) begin
            write_settings(cap_list[phase], shift_list[phase]);
            pool_size = $urandom_range(2, 20);
            for (int i = 0; i < pool_size; i++) pool[i] = $urandom >> mir_shift;
            low_mask = (32'h1 << mir_shift) - 1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 45) mode = MODE_READ;
                else if (pick < 80) mode = MODE_WRITE;
                else if (pick < 92) mode = MODE_SYNC;
                else mode = MODE_CLOSE;
                if ($urandom_range(0, 4) == 0) begin
                    addr = $urandom;
                end else begin
                    addr = (pool[$urandom_range(0, pool_size - 1)] << mir_shift) |
                           ($urandom & low_mask);
                end
                send_paced(mode, addr);
            end
            drain_block();
        end
    endtask

    initial begin
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            mir_valid[i] = 1'b0;
            mir_block[i] = '0;
            mir_count[i] = '0;
            mir_dirty[i] = 1'b0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_hit_and_fill();
        test_full_flush();
        test_capacity_and_shift();
        test_random_traffic();
        drain_block();
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog: ends a run that hangs and reports it as a failure.
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== lfu_block_cache_policy.f =====
design/lfubc_pkg.sv
design/lfubc_ctrl.sv
design/lfubc_dpath.sv
design/lfu_block_cache_policy.sv
tb/lfu_block_cache_policy_tb.sv
